FILE: rtl/core/bgns_pkg.sv
`timescale 1ns / 1ps
package bgns_pkg;

  localparam int MAX_NODES       = 1024;
  localparam int DEGREE_LIMIT    = 4;
  localparam int PATH_DEGREE     = 2;
  localparam int JUNCTION_DEGREE = 3;

  localparam int ADDR_W  = $clog2(MAX_NODES);
  localparam int DEG_W   = $clog2(DEGREE_LIMIT + 1);
  localparam int POS_W   = 24;
  localparam int RAD_W   = 20;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int REL_W   = 24;
  localparam int FRAC_W  = 14;
  localparam int DIFF_W  = POS_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int SQS_W   = SUM_W + 2 * FRAC_W;
  localparam int ROOT_W  = SQS_W / 2;
  localparam int RREM_W  = ROOT_W + 2;
  localparam int BALL_W  = 3 * POS_W + RAD_W;
  localparam int ITER_W  = 6;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_LINK    = 2'd1;
  localparam logic [1:0] OP_CONNECT = 2'd2;
  localparam logic [1:0] OP_FIND    = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TABLE_FULL = 3'd1;
  localparam logic [2:0] ST_DEG_FULL   = 3'd2;
  localparam logic [2:0] ST_BAD_INDEX  = 3'd3;
  localparam logic [2:0] ST_EMPTY      = 3'd4;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [RAD_W-1:0]        radius;
    logic [IDX_W-1:0]        index_a;
    logic [IDX_W-1:0]        index_b;
  } bgns_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic [REL_W-1:0] dist_ratio;
    logic [2:0]       status;
    logic [CNT_W-1:0] node_total;
    logic [CNT_W-1:0] end_total;
    logic [CNT_W-1:0] junction_total;
  } bgns_out_t;

  typedef enum logic [3:0] {
    DP_IDLE, DP_LATCH, DP_ERROR, DP_CAP_A, DP_CAP_B, DP_ADD, DP_LINK_A, DP_LINK_B,
    DP_SQ_X, DP_SQ_Y, DP_SQ_Z, DP_ROOT_INIT, DP_ROOT_STEP, DP_DIV_INIT, DP_DIV_STEP,
    DP_PICK_EMIT_UNUSED
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       rd_b;
    logic       pick;
    logic       emit;
    logic [2:0] code;
  } bgns_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       full;
    logic       bad_a;
    logic       bad_pair;
    logic       deg_full_a;
    logic       deg_full_b;
    logic       empty;
    logic       iter_done;
    logic       scan_last;
  } bgns_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_RD_A, S_RD_B, S_RD_W, S_CHECK, S_ADD, S_LINK_A, S_LINK_B,
    S_SC_RD, S_SC_X, S_SC_Y, S_SC_Z, S_ROOT_INIT, S_ROOT, S_DIV_INIT, S_DIV, S_PICK,
    S_DONE
  } bgns_state_t;

endpackage

FILE: rtl/core/ball_graph_nearest_search_core.sv
`timescale 1ns / 1ps
// In a search each stored ball costs three squares on one multiplier, a 40-step square
// root and a 24-step divide, one bit per cycle; the divide is skipped when the quotient
// saturates. One word in flight: the next word is taken while a result waits in the out
// register.
// Synchronous active-low reset clears all counts and control; ball storage is not cleared.
module ball_graph_nearest_search_core
  import bgns_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bgns_in_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output bgns_out_t out_word
);

  bgns_cmd_t  cmd;
  bgns_stat_t stat;

  bgns_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  bgns_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_word(in_word), .cmd(cmd), .stat(stat),
    .out_word(out_word)
  );

endmodule

FILE: rtl/core/bgns_ram.sv
`timescale 1ns / 1ps
module bgns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/bgns_dp.sv
`timescale 1ns / 1ps
module bgns_dp
  import bgns_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  bgns_in_t   in_word,
  input  bgns_cmd_t  cmd,
  output bgns_stat_t stat,
  output bgns_out_t  out_word
);

  bgns_in_t             req_r;
  logic [CNT_W-1:0]     node_cnt_r, end_cnt_r, junc_cnt_r;
  logic [DEG_W-1:0]     deg_a_r, deg_b_r;
  logic [ADDR_W-1:0]    scan_r;
  logic [SQ_W-1:0]      sq_r;
  logic [SUM_W-1:0]     sum_r;
  logic [SQS_W-1:0]     sqs_r;
  logic [ROOT_W-1:0]    root_r;
  logic [RREM_W-1:0]    rrem_r;
  logic [RAD_W-1:0]     drem_r;
  logic [REL_W-1:0]     dsh_r, dq_r;
  logic [ITER_W-1:0]    iter_r;
  logic [ADDR_W-1:0]    best_r;
  logic [REL_W-1:0]     best_rel_r;
  logic [IDX_W-1:0]     res_index_r;
  logic [REL_W-1:0]     rel_r;
  logic [2:0]           status_r;
  bgns_out_t            out_r;

  logic                 ball_we, deg_we;
  logic [ADDR_W-1:0]    ball_waddr, deg_waddr, deg_raddr;
  logic [BALL_W-1:0]    ball_wdata, ball_q;
  logic [DEG_W-1:0]     deg_wdata, deg_q, deg_new;
  logic signed [POS_W-1:0] cx, cy, cz, qsel, csel;
  logic [RAD_W-1:0]     crad;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]    mag;
  logic [SQ_W-1:0]      sq;
  logic [RREM_W+1:0]    rem2, trial;
  logic [RAD_W:0]       dt;
  logic                 dge, sat, take;

  assign cx   = ball_q[BALL_W-1 -: POS_W];
  assign cy   = ball_q[BALL_W-1-POS_W -: POS_W];
  assign cz   = ball_q[BALL_W-1-2*POS_W -: POS_W];
  assign crad = ball_q[RAD_W-1:0];

  bgns_ram #(.WIDTH(BALL_W), .DEPTH(MAX_NODES)) u_ball_ram (
    .clk(clk), .we(ball_we), .waddr(ball_waddr), .wdata(ball_wdata),
    .raddr(scan_r), .rdata(ball_q)
  );

  bgns_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
    .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .raddr(deg_raddr), .rdata(deg_q)
  );

  always_comb begin
    ball_we    = (cmd.op == DP_ADD);
    ball_waddr = ADDR_W'(node_cnt_r);
    ball_wdata = {req_r.pos_x, req_r.pos_y, req_r.pos_z, req_r.radius};
    deg_raddr  = cmd.rd_b ? ADDR_W'(req_r.index_b) : ADDR_W'(req_r.index_a);
    deg_new    = (cmd.op == DP_LINK_B) ? deg_b_r + DEG_W'(1) : deg_a_r + DEG_W'(1);
    deg_we     = 1'b0;
    deg_waddr  = ADDR_W'(node_cnt_r);
    deg_wdata  = (req_r.opcode == OP_LINK) ? DEG_W'(1) : '0;
    case (cmd.op)
      DP_ADD: begin
        deg_we = 1'b1;
      end
      DP_LINK_A: begin
        deg_we    = 1'b1;
        deg_waddr = ADDR_W'(req_r.index_a);
        deg_wdata = deg_new;
      end
      DP_LINK_B: begin
        deg_we    = 1'b1;
        deg_waddr = ADDR_W'(req_r.index_b);
        deg_wdata = deg_new;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (cmd.op)
      DP_SQ_Y: begin
        qsel = req_r.pos_y;
        csel = cy;
      end
      DP_SQ_Z: begin
        qsel = req_r.pos_z;
        csel = cz;
      end
      default: begin
        qsel = req_r.pos_x;
        csel = cx;
      end
    endcase
    diff  = DIFF_W'(qsel) - DIFF_W'(csel);
    mag   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    sq    = mag * mag;
    rem2  = {rrem_r, sqs_r[SQS_W-1 -: 2]};
    trial = (RREM_W + 2)'({root_r, 2'b01});
    dt    = {drem_r, dsh_r[REL_W-1]};
    dge   = dt >= {1'b0, crad};
    sat   = (crad == '0) || ({{(RAD_W-(ROOT_W-REL_W)){1'b0}}, root_r[ROOT_W-1:REL_W]} >= crad);
    take  = (scan_r == '0) || (dq_r < best_rel_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_cnt_r <= '0;
      end_cnt_r  <= '0;
      junc_cnt_r <= '0;
    end else begin
      case (cmd.op)
        DP_ADD: begin
          node_cnt_r <= node_cnt_r + CNT_W'(1);
          end_cnt_r  <= end_cnt_r + CNT_W'(1);
        end
        DP_LINK_A, DP_LINK_B: begin
          if (deg_new == DEG_W'(PATH_DEGREE)) begin
            end_cnt_r <= end_cnt_r - CNT_W'(1);
          end
          if (deg_new == DEG_W'(JUNCTION_DEGREE)) begin
            junc_cnt_r <= junc_cnt_r + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LATCH: begin
        req_r       <= in_word;
        scan_r      <= '0;
        status_r    <= ST_OK;
        res_index_r <= '0;
        rel_r       <= '0;
      end
      DP_ERROR: status_r <= cmd.code;
      DP_CAP_A: deg_a_r <= deg_q;
      DP_CAP_B: deg_b_r <= deg_q;
      DP_ADD: res_index_r <= IDX_W'(node_cnt_r);
      DP_SQ_X: sq_r <= sq;
      DP_SQ_Y: begin
        sum_r <= SUM_W'(sq_r);
        sq_r  <= sq;
      end
      DP_SQ_Z: begin
        sum_r <= sum_r + SUM_W'(sq_r);
        sq_r  <= sq;
      end
      DP_ROOT_INIT: begin
        sqs_r  <= {sum_r + SUM_W'(sq_r), {(2*FRAC_W){1'b0}}};
        root_r <= '0;
        rrem_r <= '0;
        iter_r <= ITER_W'(ROOT_W);
      end
      DP_ROOT_STEP: begin
        sqs_r  <= {sqs_r[SQS_W-3:0], 2'b00};
        iter_r <= iter_r - ITER_W'(1);
        if (rem2 >= trial) begin
          rrem_r <= RREM_W'(rem2 - trial);
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rrem_r <= RREM_W'(rem2);
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      DP_DIV_INIT: begin
        drem_r <= RAD_W'(root_r[ROOT_W-1:REL_W]);
        dsh_r  <= root_r[REL_W-1:0];
        if (sat) begin
          dq_r   <= '1;
          iter_r <= '0;
        end else begin
          dq_r   <= '0;
          iter_r <= ITER_W'(REL_W);
        end
      end
      DP_DIV_STEP: begin
        dsh_r  <= {dsh_r[REL_W-2:0], 1'b0};
        iter_r <= iter_r - ITER_W'(1);
        dq_r   <= {dq_r[REL_W-2:0], dge};
        drem_r <= dge ? RAD_W'(dt - {1'b0, crad}) : RAD_W'(dt);
      end
      default: ;
    endcase
    if (cmd.pick) begin
      scan_r <= scan_r + ADDR_W'(1);
      if (take) begin
        best_r      <= scan_r;
        best_rel_r  <= dq_r;
        res_index_r <= IDX_W'(scan_r);
        rel_r       <= dq_r;
      end else begin
        res_index_r <= IDX_W'(best_r);
        rel_r       <= best_rel_r;
      end
    end
    if (cmd.emit) begin
      out_r <= '{result_index: res_index_r, dist_ratio: rel_r, status: status_r,
                 node_total: node_cnt_r, end_total: end_cnt_r,
                 junction_total: junc_cnt_r};
    end
  end

  always_comb begin
    stat.opcode     = req_r.opcode;
    stat.full       = node_cnt_r >= CNT_W'(MAX_NODES);
    stat.bad_a      = CNT_W'(req_r.index_a) >= node_cnt_r;
    stat.bad_pair   = stat.bad_a || (CNT_W'(req_r.index_b) >= node_cnt_r) ||
                      (req_r.index_a == req_r.index_b);
    stat.deg_full_a = deg_a_r >= DEG_W'(DEGREE_LIMIT);
    stat.deg_full_b = deg_b_r >= DEG_W'(DEGREE_LIMIT);
    stat.empty      = node_cnt_r == '0;
    stat.iter_done  = iter_r == '0;
    stat.scan_last  = CNT_W'(scan_r) == node_cnt_r - CNT_W'(1);
  end

  assign out_word = out_r;

endmodule

FILE: rtl/core/bgns_ctrl.sv
`timescale 1ns / 1ps
module bgns_ctrl
  import bgns_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  bgns_stat_t stat,
  output bgns_cmd_t  cmd
);

  bgns_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '{op: DP_IDLE, rd_b: 1'b0, pick: 1'b0, emit: 1'b0, code: ST_OK};
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = DP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        cmd.op    = DP_ERROR;
        case (stat.opcode)
          OP_ADD: begin
            if (stat.full) cmd.code = ST_TABLE_FULL;
            else begin
              cmd.op    = DP_IDLE;
              state_nxt = S_ADD;
            end
          end
          OP_LINK: begin
            if (stat.full) cmd.code = ST_TABLE_FULL;
            else if (stat.bad_a) cmd.code = ST_BAD_INDEX;
            else begin
              cmd.op    = DP_IDLE;
              state_nxt = S_RD_A;
            end
          end
          OP_CONNECT: begin
            if (stat.bad_pair) cmd.code = ST_BAD_INDEX;
            else begin
              cmd.op    = DP_IDLE;
              state_nxt = S_RD_A;
            end
          end
          default: begin
            if (stat.empty) cmd.code = ST_EMPTY;
            else begin
              cmd.op    = DP_IDLE;
              state_nxt = S_SC_RD;
            end
          end
        endcase
      end
      S_RD_A: state_nxt = S_RD_B;
      S_RD_B: begin
        cmd.rd_b  = 1'b1;
        cmd.op    = DP_CAP_A;
        state_nxt = S_RD_W;
      end
      S_RD_W: begin
        cmd.op    = DP_CAP_B;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.opcode == OP_LINK) begin
          if (stat.deg_full_a) begin
            cmd.op    = DP_ERROR;
            cmd.code  = ST_DEG_FULL;
            state_nxt = S_DONE;
          end else state_nxt = S_ADD;
        end else begin
          if (stat.deg_full_a || stat.deg_full_b) begin
            cmd.op    = DP_ERROR;
            cmd.code  = ST_DEG_FULL;
            state_nxt = S_DONE;
          end else state_nxt = S_LINK_A;
        end
      end
      S_ADD: begin
        cmd.op    = DP_ADD;
        state_nxt = (stat.opcode == OP_LINK) ? S_LINK_A : S_DONE;
      end
      S_LINK_A: begin
        cmd.op    = DP_LINK_A;
        state_nxt = (stat.opcode == OP_CONNECT) ? S_LINK_B : S_DONE;
      end
      S_LINK_B: begin
        cmd.op    = DP_LINK_B;
        state_nxt = S_DONE;
      end
      S_SC_RD: state_nxt = S_SC_X;
      S_SC_X: begin
        cmd.op    = DP_SQ_X;
        state_nxt = S_SC_Y;
      end
      S_SC_Y: begin
        cmd.op    = DP_SQ_Y;
        state_nxt = S_SC_Z;
      end
      S_SC_Z: begin
        cmd.op    = DP_SQ_Z;
        state_nxt = S_ROOT_INIT;
      end
      S_ROOT_INIT: begin
        cmd.op    = DP_ROOT_INIT;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (stat.iter_done) state_nxt = S_DIV_INIT;
        else cmd.op = DP_ROOT_STEP;
      end
      S_DIV_INIT: begin
        cmd.op    = DP_DIV_INIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (stat.iter_done) state_nxt = S_PICK;
        else cmd.op = DP_DIV_STEP;
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = stat.scan_last ? S_DONE : S_SC_RD;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid     = out_valid_r;

endmodule
